// ===== rtl/core/pcg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair contact generation package
// Shared constants for the contact pipeline and its checker.
// ----------------------------------------------------------------------------
package pcg_pkg;

   localparam logic MODE_BOX    = 1'b0;
   localparam logic MODE_CIRCLE = 1'b1;

   localparam logic signed [15:0] Q14_POS = 16'sd16384;
   localparam logic signed [15:0] Q14_NEG = -16'sd16384;
   localparam logic [14:0]        Q14_ONE = 15'd16384;

endpackage

// ===== rtl/core/pcg_sqrt_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root stage
// One registered step of a digit-by-digit square root: brings down two bits
// of the value and settles one result bit with a single compare and subtract.
// ----------------------------------------------------------------------------
module pcg_sqrt_stage #(
   parameter int RW  = 64,
   parameter int BIT = 0
) (
   input  logic            clock,
   input  logic            enable,
   input  logic [2*RW-1:0] value_in,
   input  logic [RW+1:0]   rem_in,
   input  logic [RW-1:0]   root_in,
   output logic [2*RW-1:0] value_out,
   output logic [RW+1:0]   rem_out,
   output logic [RW-1:0]   root_out
);
   logic [2*RW-1:0] value_ff;
   logic [RW+1:0]   rem_ff;
   logic [RW-1:0]   root_ff;
   logic [RW+1:0]   rem_shift;
   logic [RW+1:0]   trial;
   logic            take;

   // The partial remainder never exceeds twice the partial root, so it fits
   // in RW bits before the next two value bits are shifted in.
   always_comb begin
      rem_shift = {rem_in[RW-1:0], value_in[2*BIT+1 -: 2]};
      trial     = {root_in, 2'b01};
      take      = rem_shift >= trial;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff <= value_in;
         rem_ff   <= take ? rem_shift - trial : rem_shift;
         root_ff  <= {root_in[RW-2:0], take};
      end
   end

   assign value_out = value_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;
endmodule

// ===== rtl/core/pair_contact_generation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair contact generation
// Box and circle pair test giving hit, unit normal toward A and depth.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Content
// req_     in         req_valid/stall    centres, half extents, radii
// rsp_     out        rsp_valid/stall    hit, normal_x, normal_y, penetration
// csr_     in         csr_write_enable   shape_mode
//
// One word enters per cycle. The datapath is a single pipeline with a valid
// bit per stage. A word passes through COORD_WIDTH+33 register stages (65 at
// the default width): two input stages, one square root stage per root bit
// (COORD_WIDTH+15), one restoring divide stage per normal quotient bit (15)
// and the output register.
// A stall at the result side freezes every stage; req_stall follows it.
// Reset (synchronous) empties the pipeline and sets shape_mode to circles.
// ----------------------------------------------------------------------------
module pair_contact_generation #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_a_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_center_y,
   input  logic [COORD_WIDTH-3:0]        req_a_half_width,
   input  logic [COORD_WIDTH-3:0]        req_a_half_height,
   input  logic [COORD_WIDTH-3:0]        req_a_radius,
   input  logic signed [COORD_WIDTH-1:0] req_b_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_center_y,
   input  logic [COORD_WIDTH-3:0]        req_b_half_width,
   input  logic [COORD_WIDTH-3:0]        req_b_half_height,
   input  logic [COORD_WIDTH-3:0]        req_b_radius,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic signed [15:0]            rsp_normal_x,
   output logic signed [15:0]            rsp_normal_y,
   output logic [COORD_WIDTH-2:0]        rsp_penetration
);
   import pcg_pkg::*;

   // Magnitudes are CW bits; the squared distance is 2*CW+1 bits and the
   // root is taken of it shifted left by 28, so the root has CW+15 bits.
   // The root consumes its value two bits per stage, so the value is padded
   // to 2*RW bits.
   localparam int CW   = COORD_WIDTH;
   localparam int MW   = CW;
   localparam int D2W  = 2 * CW + 1;
   localparam int RW   = CW + 15;
   localparam int NW   = MW + 29;
   localparam int QB   = 15;
   localparam int SQ_N = RW;
   localparam int DV_N = QB;
   localparam int DEPTH = 2 + SQ_N + DV_N + 1;

   logic advance;
   assign advance   = !rsp_stall || !rsp_valid;
   assign req_stall = !advance;

   logic mode_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CIRCLE;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   // Per-item state carried down the pipeline.
   typedef struct packed {
      logic          mode;
      logic          sx;   // dx < 0
      logic          sy;   // dy < 0
      logic [MW-1:0] mx;
      logic [MW-1:0] my;
      logic          hit;
      logic          zero;
      logic          box_x;
      logic [CW:0]   pen;  // box overlap or radius sum
   } item_type;

   logic [DEPTH-1:0] vld_ff;

   // ---------------- stage 1: differences, box overlaps, radius sum --------
   item_type s1_ff, s1_in;
   logic signed [CW:0] dx, dy;
   logic signed [CW+1:0] xo, yo;
   logic [CW-1:0] rsum;

   always_comb begin
      dx = $signed({req_b_center_x[CW-1], req_b_center_x}) -
           $signed({req_a_center_x[CW-1], req_a_center_x});
      dy = $signed({req_b_center_y[CW-1], req_b_center_y}) -
           $signed({req_a_center_y[CW-1], req_a_center_y});
      s1_in      = '0;
      s1_in.mode = mode_ff;
      s1_in.sx   = dx[CW];
      s1_in.sy   = dy[CW];
      s1_in.mx   = MW'(dx[CW] ? -dx : dx);
      s1_in.my   = MW'(dy[CW] ? -dy : dy);
      xo = $signed({2'b0, CW'(req_a_half_width)} + {2'b0, CW'(req_b_half_width)})
           - $signed({2'b0, s1_in.mx});
      yo = $signed({2'b0, CW'(req_a_half_height)} + {2'b0, CW'(req_b_half_height)})
           - $signed({2'b0, s1_in.my});
      rsum = CW'(req_a_radius) + CW'(req_b_radius);
      if (mode_ff == MODE_BOX) begin
         s1_in.hit   = (xo > 0) && (yo > 0);
         s1_in.box_x = xo < yo;
         s1_in.pen   = (CW+1)'(unsigned'(s1_in.box_x ? xo : yo));
      end else begin
         s1_in.pen = {1'b0, rsum};
      end
   end

   // ---------------- stage 2: squared distance and hit test ----------------
   item_type s2_ff, s2_in;
   logic [D2W-1:0] d2_ff, d2_in;
   logic [D2W-1:0] r2;

   always_comb begin
      s2_in = s1_ff;
      d2_in = D2W'(s1_ff.mx) * D2W'(s1_ff.mx) + D2W'(s1_ff.my) * D2W'(s1_ff.my);
      r2    = D2W'(s1_ff.pen) * D2W'(s1_ff.pen);
      if (s1_ff.mode == MODE_CIRCLE) begin
         s2_in.hit  = d2_in < r2;
         s2_in.zero = d2_in == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         d2_ff <= d2_in;
      end
   end

   // ---------------- square root: one stage per root bit -------------------
   item_type        sq_item_ff [SQ_N];
   logic [2*RW-1:0] sq_val [SQ_N+1];
   logic [RW+1:0]   sq_rem [SQ_N+1];
   logic [RW-1:0]   sq_root [SQ_N+1];

   assign sq_val[0]  = (2*RW)'({d2_ff, 28'b0});
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
      pcg_sqrt_stage #(.RW(RW), .BIT(RW - 1 - g)) u_stage (
         .clock     (clock),
         .enable    (advance),
         .value_in  (sq_val[g]),
         .rem_in    (sq_rem[g]),
         .root_in   (sq_root[g]),
         .value_out (sq_val[g+1]),
         .rem_out   (sq_rem[g+1]),
         .root_out  (sq_root[g+1])
      );
      always_ff @(posedge clock) begin
         if (advance) begin
            sq_item_ff[g] <= (g == 0) ? s2_ff : sq_item_ff[(g == 0) ? 0 : g-1];
         end
      end
   end

   // ---------------- normal divide: one stage per quotient bit -------------
   // Quotient above 2^14 clamps; only 15 bits (with an overflow flag) are
   // kept. Bits above are folded into a saturation flag taken up front.
   typedef struct packed {
      logic [NW-1:0] rem;
      logic [QB-1:0] q;
      logic          sat;
   } div_type;

   item_type      dv_item_ff [DV_N];
   logic [RW-1:0] dv_s_ff [DV_N];
   logic [CW:0]   dv_pen_ff [DV_N];
   div_type       dvx_ff [DV_N];
   div_type       dvy_ff [DV_N];

   logic [RW-1:0] s_root;
   logic [CW:0]   dist_pen;
   div_type       dvx0, dvy0;

   function automatic div_type div_init(input logic [MW-1:0] mag, input logic [RW-1:0] s);
      logic [NW+1:0] num;
      div_type r;
      num = (NW+2)'({mag, 28'b0}) + (NW+2)'(s >> 1);
      r.q   = '0;
      // Numerator scaled to start at bit QB-1 of the quotient; saturate when
      // the quotient reaches 2^15 (num >= s << 15).
      r.sat = num >= ((NW+2)'(s) << QB);
      r.rem = NW'(num);
      return r;
   endfunction

   function automatic div_type div_step(input div_type d, input logic [RW-1:0] s, input int b);
      logic [NW+QB:0] sh;
      div_type r;
      r  = d;
      sh = (NW+QB+1)'(s) << b;
      if ((NW+QB+1)'(d.rem) >= sh) begin
         r.rem  = NW'((NW+QB+1)'(d.rem) - sh);
         r.q[b] = 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      s_root   = sq_root[SQ_N];
      dist_pen = sq_item_ff[SQ_N-1].pen - (CW+1)'(s_root >> 14);
      dvx0     = div_init(sq_item_ff[SQ_N-1].mx, s_root);
      dvy0     = div_init(sq_item_ff[SQ_N-1].my, s_root);
   end

   for (genvar k = 0; k < DV_N; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (advance) begin
            if (k == 0) begin
               dv_item_ff[k] <= sq_item_ff[SQ_N-1];
               dv_s_ff[k]    <= s_root;
               dv_pen_ff[k]  <= dist_pen;
               dvx_ff[k]     <= div_step(dvx0, s_root, QB-1);
               dvy_ff[k]     <= div_step(dvy0, s_root, QB-1);
            end else begin
               dv_item_ff[k] <= dv_item_ff[(k == 0) ? 0 : k-1];
               dv_s_ff[k]    <= dv_s_ff[(k == 0) ? 0 : k-1];
               dv_pen_ff[k]  <= dv_pen_ff[(k == 0) ? 0 : k-1];
               dvx_ff[k]     <= div_step(dvx_ff[(k == 0) ? 0 : k-1],
                                         dv_s_ff[(k == 0) ? 0 : k-1], QB-1-k);
               dvy_ff[k]     <= div_step(dvy_ff[(k == 0) ? 0 : k-1],
                                         dv_s_ff[(k == 0) ? 0 : k-1], QB-1-k);
            end
         end
      end
   end

   // ---------------- output register ---------------------------------------
   item_type f;
   logic [CW:0] pen_raw;
   logic [14:0] qx, qy;
   logic out_hit_in;
   logic signed [15:0] nx_in, ny_in;
   logic [CW-2:0] pen_in;

   always_comb begin
      f  = dv_item_ff[DV_N-1];
      qx = (dvx_ff[DV_N-1].sat || dvx_ff[DV_N-1].q > Q14_ONE) ? Q14_ONE : dvx_ff[DV_N-1].q;
      qy = (dvy_ff[DV_N-1].sat || dvy_ff[DV_N-1].q > Q14_ONE) ? Q14_ONE : dvy_ff[DV_N-1].q;
      out_hit_in = f.hit;
      nx_in   = '0;
      ny_in   = '0;
      pen_raw = '0;
      if (f.hit) begin
         if (f.mode == MODE_BOX) begin
            pen_raw = f.pen;
            if (f.box_x) begin
               nx_in = f.sx ? Q14_POS : Q14_NEG;
            end else begin
               ny_in = f.sy ? Q14_POS : Q14_NEG;
            end
         end else if (f.zero) begin
            pen_raw = f.pen;
            ny_in   = Q14_NEG;
         end else begin
            pen_raw = dv_pen_ff[DV_N-1];
            nx_in   = f.sx ? $signed({1'b0, qx}) : -$signed({1'b0, qx});
            ny_in   = f.sy ? $signed({1'b0, qy}) : -$signed({1'b0, qy});
         end
      end
      pen_in = (pen_raw[CW:CW-1] != 2'b00) ? {(CW-1){1'b1}} : pen_raw[CW-2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit         <= out_hit_in;
         rsp_normal_x    <= nx_in;
         rsp_normal_y    <= ny_in;
         rsp_penetration <= pen_in;
      end
   end

   assign rsp_valid = vld_ff[DEPTH-1];
endmodule

// ===== rtl/core/pcg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair contact generation checker
// Port-level properties of the contact pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module pcg_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   req_stall,
   input logic                   rsp_hit,
   input logic signed [15:0]     rsp_normal_x,
   input logic signed [15:0]     rsp_normal_y,
   input logic [COORD_WIDTH-2:0] rsp_penetration
);
   import pcg_pkg::*;

   // A word that misses carries no normal and no depth.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_normal_x == 0 && rsp_normal_y == 0 &&
      rsp_penetration == 0) else $error("miss with nonzero contact");

   // A hit always carries a nonzero depth.
   a_hit_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_penetration != 0) else $error("hit with zero depth");

   // Input back-pressure only while a result waits stalled.
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall) else $error("input stalled without cause");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_penetration))
      else $error("stalled result changed");
endmodule

bind pair_contact_generation pcg_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pcg_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .req_stall       (req_stall),
   .rsp_hit         (rsp_hit),
   .rsp_normal_x    (rsp_normal_x),
   .rsp_normal_y    (rsp_normal_y),
   .rsp_penetration (rsp_penetration)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair contact generation testbench
// Drives box and circle shape pairs through the contact block, with a short
// directed table followed by random pairs in both shape modes. Every contact
// word that comes back is compared field by field with the oldest expected
// contact (typed or predicted in-bench). Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import pcg_pkg::*;

   localparam int          PERIOD       = 20;
   localparam int          DRAIN_CYCLES = 400;
   localparam int          WATCHDOG     = 20000;
   localparam int          RANDOM_ITEMS = 1150;
   localparam int          PHASES       = 6;
   localparam logic [31:0] COORD_MAX    = 32'h7fffffff;
   localparam logic [31:0] COORD_MIN    = 32'h80000000;
   localparam logic [31:0] EXTENT_MAX   = 32'h3fffffff;

   typedef struct packed {
      logic [31:0] ax;
      logic [31:0] ay;
      logic [29:0] a_hw;
      logic [29:0] a_hh;
      logic [29:0] a_r;
      logic [31:0] bx;
      logic [31:0] by;
      logic [29:0] b_hw;
      logic [29:0] b_hh;
      logic [29:0] b_r;
   } pair_type;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic [30:0]        depth;
   } contact_type;

   typedef struct packed {
      logic        mode;
      logic        typed;
      pair_type    pair;
      contact_type want;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic               csr_write_data = 1'b0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   pair_type           req_pair = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_hit;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic [30:0]        rsp_penetration;

   // The shape mode as the block holds it; it comes up in circle mode.
   logic               shape_mode = MODE_CIRCLE;
   contact_type        pending_contacts[$];
   int                 mismatches = 0;
   int                 idle_cycles = 0;
   bit                 send_quiet = 1'b0;
   bit                 stall_quiet = 1'b0;
   int                 stall_left = 0;
   int                 words_seen = 0;

   always #(PERIOD / 2) clock = ~clock;

   pair_contact_generation #(.COORD_WIDTH(32)) i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_a_center_x    (req_pair.ax),
      .req_a_center_y    (req_pair.ay),
      .req_a_half_width  (req_pair.a_hw),
      .req_a_half_height (req_pair.a_hh),
      .req_a_radius      (req_pair.a_r),
      .req_b_center_x    (req_pair.bx),
      .req_b_center_y    (req_pair.by),
      .req_b_half_width  (req_pair.b_hw),
      .req_b_half_height (req_pair.b_hh),
      .req_b_radius      (req_pair.b_r),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_normal_x      (rsp_normal_x),
      .rsp_normal_y      (rsp_normal_y),
      .rsp_penetration   (rsp_penetration)
   );

   // Integer square root, floor, of a value below 2^128.
   function automatic logic [63:0] isqrt(logic [127:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if ({64'd0, trial} * {64'd0, trial} <= v) root = trial;
      end
      return root;
   endfunction

   // One normal component of a circle contact: |d| / distance in Q1.14,
   // rounded half up, clamped to one, pointing from B toward A.
   function automatic logic signed [15:0] circle_normal(logic [63:0] mag, bit b_below,
                                                         logic [63:0] root);
      logic [127:0] quo;
      logic [63:0]  q;
      quo = (({64'd0, mag} << 28) + {65'd0, root[63:1]}) / {64'd0, root};
      q = quo[63:0];
      if (q > 64'd16384) q = 64'd16384;
      return b_below ? q[15:0] : -q[15:0];
   endfunction

   function automatic contact_type predict_contact(pair_type p, logic mode);
      contact_type  c;
      longint       dx, dy, mx, my, x_pen, y_pen;
      logic [63:0]  rsum, root;
      logic [127:0] d2, r2;
      c = '0;
      dx = longint'($signed(p.bx)) - longint'($signed(p.ax));
      dy = longint'($signed(p.by)) - longint'($signed(p.ay));
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      if (mode == MODE_BOX) begin
         x_pen = longint'(p.a_hw) + longint'(p.b_hw) - mx;
         y_pen = longint'(p.a_hh) + longint'(p.b_hh) - my;
         if (x_pen > 0 && y_pen > 0) begin
            c.hit = 1'b1;
            // The thinner overlap wins; a tie goes to the y axis.
            if (x_pen < y_pen) begin
               c.nx = dx < 0 ? Q14_POS : Q14_NEG;
               c.depth = x_pen[30:0];
            end else begin
               c.ny = dy < 0 ? Q14_POS : Q14_NEG;
               c.depth = y_pen[30:0];
            end
         end
      end else begin
         rsum = 64'(p.a_r) + 64'(p.b_r);
         d2 = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
         r2 = {64'd0, rsum} * {64'd0, rsum};
         if (d2 < r2) begin
            c.hit = 1'b1;
            if (d2 == '0) begin
               // Coincident centres have no direction, so the normal is down.
               c.ny = Q14_NEG;
               c.depth = rsum[30:0];
            end else begin
               root = isqrt(d2 << 28);
               c.depth = 31'(rsum - (root >> 14));
               c.nx = circle_normal(64'(mx), dx < 0, root);
               c.ny = circle_normal(64'(my), dy < 0, root);
            end
         end
      end
      return c;
   endfunction

   function automatic pair_type make_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] a_hw,
                                          logic [31:0] a_hh, logic [31:0] a_r,
                                          logic [31:0] bx, logic [31:0] by, logic [31:0] b_hw,
                                          logic [31:0] b_hh, logic [31:0] b_r);
      return '{ax, ay, a_hw[29:0], a_hh[29:0], a_r[29:0],
               bx, by, b_hw[29:0], b_hh[29:0], b_r[29:0]};
   endfunction

   // A magnitude of random bit length, so that both tiny and huge sizes occur.
   function automatic logic [31:0] random_size(int max_bits);
      int bits;
      bits = $urandom_range(1, max_bits);
      return 32'($urandom & ((64'd1 << bits) - 64'd1));
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      logic [31:0] ox, oy;
      p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom);
      // Most pairs sit close together with sizes of random bit length, so contacts
      // are common; the rest stay fully random and mostly miss.
      if ($urandom_range(0, 9) < 8) begin
         ox = random_size(31);
         oy = random_size(31);
         p.bx = $urandom_range(0, 1) ? p.ax + ox : p.ax - ox;
         p.by = $urandom_range(0, 1) ? p.ay + oy : p.ay - oy;
         p.a_hw = 30'(random_size(30));
         p.a_hh = 30'(random_size(30));
         p.a_r = 30'(random_size(30));
         p.b_hw = 30'(random_size(30));
         p.b_hh = 30'(random_size(30));
         p.b_r = 30'(random_size(30));
      end
      return p;
   endfunction

   task automatic write_shape_mode(logic mode);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shape_mode = mode;
   endtask

   task automatic wait_for_contacts();
      while (pending_contacts.size() != 0) @(posedge clock);
   endtask

   // Offers one pair and returns at the edge where it was taken. The valid
   // stays high into the next word unless a gap is drawn.
   task automatic send_pair(pair_type p, bit typed, contact_type want);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pair <= p;
      do @(posedge clock); while (req_stall);
      pending_contacts.insert(pending_contacts.size(),
                              typed ? want : predict_contact(p, shape_mode));
   endtask

   // Result side: checks each taken word and draws the stall before the next.
   always @(posedge clock) begin
      contact_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_hit, rsp_normal_x, rsp_normal_y, rsp_penetration};
         words_seen++;
         if (words_seen % 50 == 0) stall_quiet = ($urandom_range(0, 3) == 0);
         stall_left = stall_quiet ? 0 : $urandom_range(0, 13);
         if (pending_contacts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected contact word %p", got);
         end else begin
            want = pending_contacts.pop_front();
            if (got.hit !== want.hit || got.nx !== want.nx || got.ny !== want.ny ||
                got.depth !== want.depth) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("contact mismatch: hit %0b/%0b nx %0d/%0d ny %0d/%0d depth %0d/%0d",
                           want.hit, got.hit, want.nx, got.nx, want.ny, got.ny,
                           want.depth, got.depth);
            end
         end
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: the run is hung if neither side takes a word for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      row_type rows[$];
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Rows marked typed carry a contact that can be read
      // straight off the geometry; the others rely on the predictor.
      rows = '{
         // Boxes with zero size touch nothing, even at the same centre.
         '{MODE_BOX, 1'b1, make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), '0},
         // B right of A: the x overlap is thinner, normal points left.
         '{MODE_BOX, 1'b1, make_pair(0, 0, 32'h20000, 32'h20000, 0,
                                     32'h10000, 0, 32'h20000, 32'h20000, 0),
           '{1'b1, Q14_NEG, 16'sd0, 31'd196608}},
         // Equal overlaps go to y; equal centres give the downward normal.
         '{MODE_BOX, 1'b1, make_pair(0, 0, 32'h10000, 32'h10000, 0,
                                     0, 0, 32'h10000, 32'h10000, 0),
           '{1'b1, 16'sd0, Q14_NEG, 31'd131072}},
         '{MODE_BOX, 1'b0, make_pair(32'h30000, 32'h50000, 32'h20000, 32'h40000, 0,
                                     32'h10000, 32'h18000, 32'h20000, 32'h10000, 0), '0},
         '{MODE_BOX, 1'b0, make_pair(32'h50000, 32'h10000, 32'h40000, 32'h20000, 0,
                                     32'h10000, 32'h20000, 32'h10000, 32'h20000, 0), '0},
         // Opposite corners of the coordinate range never meet.
         '{MODE_BOX, 1'b1, make_pair(COORD_MAX, COORD_MAX, EXTENT_MAX, EXTENT_MAX, 0,
                                     COORD_MIN, COORD_MIN, EXTENT_MAX, EXTENT_MAX, 0), '0},
         '{MODE_BOX, 1'b1, make_pair(COORD_MIN, COORD_MAX, EXTENT_MAX, EXTENT_MAX,
                                     EXTENT_MAX, COORD_MIN, COORD_MAX, EXTENT_MAX,
                                     EXTENT_MAX, EXTENT_MAX),
           '{1'b1, 16'sd0, Q14_NEG, 31'd2147483646}},
         // Circles of zero radius at one point do not hit.
         '{MODE_CIRCLE, 1'b1, make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), '0},
         '{MODE_CIRCLE, 1'b1, make_pair(32'h10000, 32'h10000, 0, 0, 32'h10000,
                                        32'h10000, 32'h10000, 0, 0, 0),
           '{1'b1, 16'sd0, Q14_NEG, 31'd65536}},
         '{MODE_CIRCLE, 1'b1, make_pair(0, 0, 0, 0, 32'h20000, 32'h30000, 0, 0, 0, 32'h20000),
           '{1'b1, Q14_NEG, 16'sd0, 31'd65536}},
         // Circles that just touch are not a hit.
         '{MODE_CIRCLE, 1'b1, make_pair(0, 0, 0, 0, 32'h20000, 32'h40000, 0, 0, 0, 32'h20000),
           '0},
         '{MODE_CIRCLE, 1'b0, make_pair(32'h10000, 32'h20000, 0, 0, 32'h50000,
                                        32'h40000, 32'h60000, 0, 0, 32'h30000), '0},
         '{MODE_CIRCLE, 1'b0, make_pair(32'h40000, 32'h60000, 0, 0, 32'h30000,
                                        32'h10000, 32'h20000, 0, 0, 32'h50000), '0},
         '{MODE_CIRCLE, 1'b0, make_pair(COORD_MIN, COORD_MIN, 0, 0, EXTENT_MAX,
                                        COORD_MAX, COORD_MAX, 0, 0, EXTENT_MAX), '0},
         '{MODE_CIRCLE, 1'b0, make_pair(0, 0, 0, 0, EXTENT_MAX, 32'h1, 32'hffffffff,
                                        0, 0, EXTENT_MAX), '0},
         '{MODE_CIRCLE, 1'b1, make_pair(COORD_MAX, COORD_MIN, 0, 0, EXTENT_MAX,
                                        COORD_MAX, COORD_MIN, 0, 0, EXTENT_MAX),
           '{1'b1, 16'sd0, Q14_NEG, 31'd2147483646}}
      };

      foreach (rows[i]) begin
         if (rows[i].mode != shape_mode) begin
            req_valid <= 1'b0;
            wait_for_contacts();
            write_shape_mode(rows[i].mode);
         end
         send_pair(rows[i].pair, rows[i].typed, rows[i].want);
      end

      // Random phases alternate the shape mode, each after the pipe drains.
      for (int ph = 0; ph < PHASES; ph++) begin
         req_valid <= 1'b0;
         wait_for_contacts();
         write_shape_mode(ph % 2 == 0 ? MODE_BOX : MODE_CIRCLE);
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            if (n % 50 == 0) send_quiet = ($urandom_range(0, 3) == 0);
            send_pair(random_pair(), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      wait_for_contacts();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_contacts.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
